@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the sorted value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SVT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/svt_pkg.sv @@
// Shared constants and types of the sorted value table.
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

    localparam int DEPTH    = 16;
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        logic gt;
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_value_table_top.sv @@
// Top level of the sorted value table: cell chain, operation control and result register.
`timescale 1ns / 1ps
`default_nettype none

// The table keeps up to DEPTH signed values in ascending order in a chain of cells.
// Insert, delete and an unused operation code each give one result beat; the
// whole chain compares the value in parallel and shifts as the item is accepted.
// A dump of N stored entries gives N beats, one per cycle while the output is not
// stalled, by rotating the chain through its head cell; a dump of an empty table
// gives one beat. Results sit in an output register, so a new item is accepted in
// the cycle in which the final beat of the previous item is taken.
module sorted_value_table_top
    import svt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     op,
    input  wire value_t              value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output value_t                   entry_value,
    output logic [ECOUNT_W-1:0]      entry_count,
    output logic                     last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    value_t                entry_value_reg, entry_value_next;
    logic [COUNT_W-1:0]    entry_count_reg, entry_count_next;
    logic                  last_reg, last_next;

    cell_cmd_t             cmd;
    value_t                cell_value [DEPTH];
    cell_flags_t           cell_flags [DEPTH];
    logic [DEPTH-1:0]      occ;
    logic [DEPTH-1:0]      eq_vec;
    logic                  found;
    logic                  out_free;
    logic                  fire_in;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign fire_in  = in_valid && in_ready;
    assign found    = |eq_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   prv_shift;
            value_t prv_value;
            logic   nxt_occupied;
            value_t nxt_value;

            assign occ[g]    = (COUNT_W'(g) < count_reg);
            assign eq_vec[g] = cell_flags[g].eq;

            if (g == 0)
            begin : g_first
                assign prv_shift = 1'b0;
                assign prv_value = cell_value[0];
            end
            else
            begin : g_mid
                assign prv_shift = cell_flags[g-1].gt;
                assign prv_value = cell_value[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign nxt_occupied = 1'b0;
                assign nxt_value    = cell_value[g];
            end
            else
            begin : g_inner
                assign nxt_occupied = occ[g+1];
                assign nxt_value    = cell_value[g+1];
            end

            svt_cell u_cell (
                .clk          (clk),
                .cmd          (cmd),
                .key          (value),
                .occupied     (occ[g]),
                .prv_shift    (prv_shift),
                .prv_value    (prv_value),
                .nxt_occupied (nxt_occupied),
                .nxt_value    (nxt_value),
                .head_value   (cell_value[0]),
                .value        (cell_value[g]),
                .flags        (cell_flags[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        cmd              = CELL_HOLD;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        entry_value_next = entry_value_reg;
        entry_count_next = entry_count_reg;
        last_next        = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (fire_in)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = STATUS_OK;
                    entry_value_next = '0;
                    last_next        = 1'b1;
                    case (op)
                        OP_INSERT:
                        begin
                            if (count_reg == COUNT_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cmd        = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (!found)
                            begin
                                status_next = STATUS_MISSING;
                            end
                            else
                            begin
                                cmd        = CELL_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd              = CELL_ROTATE;
                                entry_value_next = cell_value[0];
                                if (count_reg != COUNT_W'(1))
                                begin
                                    last_next  = 1'b0;
                                    idx_next   = IDX_W'(1);
                                    state_next = ST_DUMP;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                    entry_count_next = count_next;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    cmd              = CELL_ROTATE;
                    out_valid_next   = 1'b1;
                    status_next      = STATUS_OK;
                    entry_value_next = cell_value[0];
                    entry_count_next = count_reg;
                    last_next        = (COUNT_W'(idx_reg) == count_reg - 1'b1);
                    idx_next         = idx_reg + 1'b1;
                    if (last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        entry_value_reg <= entry_value_next;
        entry_count_reg <= entry_count_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_value = entry_value_reg;
    assign entry_count = ECOUNT_W'(entry_count_reg);
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ rtl/core/svt_cell.sv @@
// One storage cell of the sorted chain: holds a value and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module svt_cell
    import svt_pkg::*;
(
    input  wire logic        clk,
    input  wire cell_cmd_t   cmd,
    input  wire value_t      key,
    input  wire logic        occupied,
    input  wire logic        prv_shift,
    input  wire value_t      prv_value,
    input  wire logic        nxt_occupied,
    input  wire value_t      nxt_value,
    input  wire value_t      head_value,
    output value_t           value,
    output cell_flags_t      flags
);

    value_t value_reg;
    value_t value_next;

    assign value    = value_reg;
    assign flags.gt = occupied && (value_reg > key);
    assign flags.ge = occupied && (value_reg >= key);
    assign flags.eq = occupied && (value_reg == key);

    always_comb
    begin
        value_next = value_reg;
        case (cmd)
            CELL_INSERT:
            begin
                if (prv_shift)
                begin
                    value_next = prv_value;
                end
                else if (!occupied || flags.gt)
                begin
                    value_next = key;
                end
            end
            CELL_DELETE:
            begin
                if (flags.ge)
                begin
                    value_next = nxt_value;
                end
            end
            CELL_ROTATE:
            begin
                if (occupied)
                begin
                    value_next = nxt_occupied ? nxt_value : head_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/svt_checker.sv @@
// Port-level assertions of the sorted value table and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module svt_checker
    import svt_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic [OP_W-1:0]     op,
    input wire value_t              value,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire value_t              entry_value,
    input wire logic [ECOUNT_W-1:0] entry_count,
    input wire logic                last
);

    logic [OP_W+VALUE_W-1:0]                   in_beat;
    logic [STATUS_W+VALUE_W+ECOUNT_W:0]        out_beat;

    assign in_beat  = {op, value};
    assign out_beat = {status, entry_value, entry_count, last};

    // A dump beat that is not the final one means the table is still streaming.
    `SVT_ASSERT_NOW(a_no_accept_mid_dump, out_valid && !last, !in_ready)

    // Any failure status ends its item and carries no entry.
    `SVT_ASSERT_NOW(a_fail_is_single, out_valid && status != STATUS_OK, last && entry_value == '0)

    // A dump beat that is not final carries an OK status and a nonzero entry count.
    `SVT_ASSERT_NOW(a_mid_dump_count, out_valid && !last, entry_count != '0 && status == STATUS_OK)

    // A stalled beat holds its payload.
    `SVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

    // A waiting input beat stays offered with its payload unchanged.
    `SVT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_beat))

endmodule

bind sorted_value_table_top svt_checker u_svt_checker (.*);

`default_nettype wire
